FILE: rtl/core/bpm_pkg.sv
// ----------------------------------------------------------------------------
// bpm_pkg
// Shared widths, register indexes and reset values of the probability merge.
// ----------------------------------------------------------------------------
package bpm_pkg;

   localparam int PROB_W  = 8;
   localparam int COUNT_W = 32;
   localparam int TOTAL_W = COUNT_W + 1;
   localparam int NUM_W   = COUNT_W + PROB_W + 1;
   localparam int SAT_W   = 8;
   localparam int FAC_W   = 9;
   localparam int WNUM_W  = FAC_W + SAT_W;
   localparam int QUO_W   = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_COEF_SAT     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_FAC     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_FAC_KEY = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AFTER_KEY    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE_SAT     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE_FAC     = 3'd5;

   localparam logic [SAT_W-1:0] RST_COEF_SAT     = 8'd24;
   localparam logic [FAC_W-1:0] RST_COEF_FAC     = 9'd112;
   localparam logic [FAC_W-1:0] RST_COEF_FAC_KEY = 9'd128;
   localparam logic [SAT_W-1:0] RST_MODE_SAT     = 8'd20;
   localparam logic [FAC_W-1:0] RST_MODE_FAC     = 9'd128;

   localparam logic [FAC_W-1:0]  FAC_MAX   = 9'd256;
   localparam logic [PROB_W-1:0] PROB_HALF = 8'd128;
   localparam logic [PROB_W-1:0] PROB_MAX  = 8'd255;
   localparam logic [PROB_W-1:0] PROB_MIN  = 8'd1;

   localparam int DIV_LAT = QUO_W;
   localparam int LATENCY = DIV_LAT + 4;

endpackage

FILE: rtl/core/bpm_div.sv
// ----------------------------------------------------------------------------
// bpm_div
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// ----------------------------------------------------------------------------
module bpm_div
   import bpm_pkg::*;
#(
   parameter int NW = NUM_W,
   parameter int DW = TOTAL_W,
   parameter int QW = QUO_W,
   parameter int TW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_vld,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [TW-1:0] in_tag,
   output logic          out_vld,
   output logic [QW-1:0] out_quo,
   output logic [TW-1:0] out_tag
);

   localparam int XW = DW + QW;

   logic [XW-1:0] rem_ff [QW];
   logic [DW-1:0] den_ff [QW];
   logic [QW-1:0] quo_ff [QW];
   logic [TW-1:0] tag_ff [QW];
   logic          vld_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [XW-1:0] r_src;
      logic [DW-1:0] d_src;
      logic [QW-1:0] q_src;
      logic [TW-1:0] t_src;
      logic          v_src;
      logic [XW-1:0] sh;
      logic          ge;

      if (k == 0) begin : g_first
         assign r_src = XW'(in_num);
         assign d_src = in_den;
         assign q_src = '0;
         assign t_src = in_tag;
         assign v_src = in_vld;
      end else begin : g_next
         assign r_src = rem_ff[k-1];
         assign d_src = den_ff[k-1];
         assign q_src = quo_ff[k-1];
         assign t_src = tag_ff[k-1];
         assign v_src = vld_ff[k-1];
      end

      assign sh = XW'(d_src) << (QW - 1 - k);
      assign ge = r_src >= sh;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= v_src;
         end
         rem_ff[k] <= ge ? r_src - sh : r_src;
         den_ff[k] <= d_src;
         quo_ff[k] <= {q_src[QW-2:0], ge};
         tag_ff[k] <= t_src;
      end
   end

   assign out_vld = vld_ff[QW-1];
   assign out_quo = quo_ff[QW-1];
   assign out_tag = tag_ff[QW-1];

endmodule

FILE: rtl/core/binary_prob_merge.sv
// ----------------------------------------------------------------------------
// binary_prob_merge
// Backward probability adaptation of one binary tree node.
//
//   channel  ports                       handshake
//   request  start/busy, req_*           start && !busy
//   result   rsp_strobe, rsp_new_prob    one-cycle strobe, no back-pressure
//   csr      csr_valid/csr_ready, csr_*  csr_valid && csr_ready
//
// A word enters every cycle; its result passes the input register, the nine
// divider stages, then the select, multiply and blend registers.
// busy stays low: nothing ever stalls the pipeline.
// Reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module binary_prob_merge
   import bpm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_type,
   input  logic [PROB_W-1:0]     req_old_prob,
   input  logic [COUNT_W-1:0]    req_left_count,
   input  logic [COUNT_W-1:0]    req_right_count,
   output logic                  rsp_strobe,
   output logic [PROB_W-1:0]     rsp_new_prob,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [SAT_W-1:0] coef_sat_ff;
   logic [FAC_W-1:0] coef_fac_ff;
   logic [FAC_W-1:0] coef_fac_key_ff;
   logic             after_key_ff;
   logic [SAT_W-1:0] mode_sat_ff;
   logic [FAC_W-1:0] mode_fac_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_sat_ff     <= RST_COEF_SAT;
         coef_fac_ff     <= RST_COEF_FAC;
         coef_fac_key_ff <= RST_COEF_FAC_KEY;
         after_key_ff    <= 1'b0;
         mode_sat_ff     <= RST_MODE_SAT;
         mode_fac_ff     <= RST_MODE_FAC;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_COEF_SAT:     coef_sat_ff     <= csr_data[SAT_W-1:0];
            CSR_COEF_FAC:     coef_fac_ff     <= csr_data;
            CSR_COEF_FAC_KEY: coef_fac_key_ff <= csr_data;
            CSR_AFTER_KEY:    after_key_ff    <= csr_data[0];
            CSR_MODE_SAT:     mode_sat_ff     <= csr_data[SAT_W-1:0];
            CSR_MODE_FAC:     mode_fac_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // input stage
   logic [TOTAL_W-1:0] total;
   logic [SAT_W-1:0]   sat_sel;
   logic [FAC_W-1:0]   fac_sel;
   logic [FAC_W-1:0]   fac_clip;
   logic [SAT_W-1:0]   cnt;

   assign total    = {1'b0, req_left_count} + {1'b0, req_right_count};
   assign sat_sel  = req_type ? mode_sat_ff : coef_sat_ff;
   assign fac_sel  = req_type ? mode_fac_ff : (after_key_ff ? coef_fac_key_ff : coef_fac_ff);
   assign fac_clip = (fac_sel > FAC_MAX) ? FAC_MAX : fac_sel;
   assign cnt      = (total < TOTAL_W'(sat_sel)) ? total[SAT_W-1:0] : sat_sel;

   logic               s0_vld_ff;
   logic [NUM_W-1:0]   s0_num_ff;
   logic [TOTAL_W-1:0] s0_den_ff;
   logic [WNUM_W-1:0]  s0_wnum_ff;
   logic [SAT_W-1:0]   s0_sat_ff;
   logic [PROB_W-1:0]  s0_old_ff;
   logic               s0_cz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff <= start && !busy;
      end
      s0_num_ff  <= {req_left_count, {PROB_W{1'b0}}} + NUM_W'(total >> 1);
      s0_den_ff  <= total;
      s0_wnum_ff <= fac_clip * cnt;
      s0_sat_ff  <= sat_sel;
      s0_old_ff  <= req_old_prob;
      s0_cz_ff   <= total == '0;
   end

   // dividers
   logic              cd_vld;
   logic [QUO_W-1:0]  cd_quo;
   logic [PROB_W:0]   cd_tag;
   logic              wd_vld;
   logic [QUO_W-1:0]  wd_quo;
   logic              wd_tag;

   bpm_div #(
      .NW(NUM_W), .DW(TOTAL_W), .QW(QUO_W), .TW(PROB_W + 1)
   ) u_cdiv (
      .clock(clock), .reset(reset),
      .in_vld(s0_vld_ff), .in_num(s0_num_ff), .in_den(s0_den_ff),
      .in_tag({s0_old_ff, s0_cz_ff}),
      .out_vld(cd_vld), .out_quo(cd_quo), .out_tag(cd_tag)
   );

   bpm_div #(
      .NW(WNUM_W), .DW(SAT_W), .QW(QUO_W), .TW(1)
   ) u_wdiv (
      .clock(clock), .reset(reset),
      .in_vld(s0_vld_ff), .in_num(s0_wnum_ff), .in_den(s0_sat_ff),
      .in_tag(s0_sat_ff == '0),
      .out_vld(wd_vld), .out_quo(wd_quo), .out_tag(wd_tag)
   );

   // clip and select
   logic [PROB_W-1:0] cp;

   always_comb begin
      priority if (cd_tag[0]) begin
         cp = PROB_HALF;
      end else if (cd_quo > QUO_W'(PROB_MAX)) begin
         cp = PROB_MAX;
      end else if (cd_quo == '0) begin
         cp = PROB_MIN;
      end else begin
         cp = cd_quo[PROB_W-1:0];
      end
   end

   logic              s1_vld_ff;
   logic [PROB_W-1:0] s1_cp_ff;
   logic [FAC_W-1:0]  s1_w_ff;
   logic [PROB_W-1:0] s1_old_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= cd_vld;
      end
      s1_cp_ff  <= cp;
      s1_w_ff   <= wd_tag ? '0 : wd_quo;
      s1_old_ff <= cd_tag[PROB_W:1];
   end

   // weight products
   localparam int PROD_W = PROB_W + FAC_W;

   logic              s2_vld_ff;
   logic [PROD_W-1:0] s2_pa_ff;
   logic [PROD_W-1:0] s2_pb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
      s2_pa_ff <= s1_old_ff * (FAC_MAX - s1_w_ff);
      s2_pb_ff <= s1_cp_ff * s1_w_ff;
   end

   // blend and round
   logic [PROD_W:0] blend_sum;

   assign blend_sum = {1'b0, s2_pa_ff} + {1'b0, s2_pb_ff} + (PROD_W + 1)'(PROB_HALF);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= s2_vld_ff;
      end
      rsp_new_prob <= blend_sum[PROB_W +: PROB_W];
   end

   // checks
   a_div_align: assert property (@(posedge clock) disable iff (reset) cd_vld == wd_vld)
      else $error("divider valids out of step");
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##LATENCY rsp_strobe)
      else $error("accepted word produced no result");
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, LATENCY))
      else $error("result without accepted word");

endmodule
